// ===== src/sch3_pkg.sv =====
// Shared types and constants for the Scharr 3x3 gradient block.
// No dependencies; imported by every module of the block but sch3_ram.

package sch3_pkg;

	// line store geometry
	localparam int MAX_WIDTH = 4096;
	localparam int ADDR_W    = $clog2(MAX_WIDTH);

	// field widths
	localparam int PIX_W      = 8;
	localparam int GRAD_W     = 13;
	localparam int WIDTH_W    = 13;
	localparam int HEIGHT_W   = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// register reset values
	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);

	// kernel weights: outer taps and center tap
	localparam int KERN_SIDE = 3;
	localparam int KERN_MID  = 10;

	// window size of the filter
	localparam int WIN_SIZE = 3;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	// per-pixel control info travelling down the pipeline
	typedef struct packed {
		logic produce;
		logic row_end;
		logic frame_end;
	} item_tag_t;

endpackage

// ===== src/sch3_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the line store of the gradient block, which holds both rows.

module sch3_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 256,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read, holds while rd_en is low
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/sch3_ctrl.sv =====
// Configuration registers and raster position counters for the gradient block.
// Depends on sch3_pkg; gives the line store address and item tag per pixel.

module sch3_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sch3_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sch3_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             advance,
	output logic [sch3_pkg::ADDR_W-1:0]      addr,
	output sch3_pkg::item_tag_t              tag
);
	import sch3_pkg::*;

	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [ADDR_W-1:0]   col_q;
	logic [HEIGHT_W-1:0] row_q;

	logic [ADDR_W-1:0]   last_col;
	logic [HEIGHT_W-1:0] last_row;
	logic                size_ok;
	logic                at_col_end;
	logic                at_row_end;

	// effective last column: zero width acts as one, wide images saturate
	always_comb begin
		if (width_q == '0) begin
			last_col = '0;
		end else if (32'(width_q) > MAX_WIDTH) begin
			last_col = ADDR_W'(MAX_WIDTH - 1);
		end else begin
			last_col = ADDR_W'(width_q - WIDTH_W'(1));
		end
	end

	assign last_row   = (height_q == '0) ? '0 : height_q - HEIGHT_W'(1);
	assign size_ok    = (width_q >= WIDTH_W'(WIN_SIZE)) && (height_q >= HEIGHT_W'(WIN_SIZE));
	assign at_col_end = (col_q == last_col);
	assign at_row_end = (row_q == last_row);

	// tag for the pixel at the current position
	assign addr          = col_q;
	assign tag.produce   = size_ok && (row_q >= HEIGHT_W'(WIN_SIZE - 1))
		&& (col_q >= ADDR_W'(WIN_SIZE - 1));
	assign tag.row_end   = at_col_end;
	assign tag.frame_end = at_col_end && at_row_end;

	// configuration writes restart the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH: begin
					width_q <= cfg_data[WIDTH_W-1:0];
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= cfg_data[HEIGHT_W-1:0];
				end
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (at_col_end) begin
				col_q <= '0;
				row_q <= at_row_end ? '0 : row_q + HEIGHT_W'(1);
			end else begin
				col_q <= col_q + ADDR_W'(1);
			end
		end
	end

endmodule

// ===== src/sch3_window.sv =====
// 3x3 window column registers and the Scharr x/y gradient arithmetic.
// Depends on sch3_pkg; the incoming column comes from the line stores.

module sch3_window (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               shift_en,
	input  logic [sch3_pkg::PIX_W-1:0]         top,
	input  logic [sch3_pkg::PIX_W-1:0]         mid,
	input  logic [sch3_pkg::PIX_W-1:0]         bot,
	output logic signed [sch3_pkg::GRAD_W-1:0] grad_x,
	output logic signed [sch3_pkg::GRAD_W-1:0] grad_y
);
	import sch3_pkg::*;

	localparam int SUM_W = GRAD_W + 1;
	localparam logic signed [SUM_W-1:0] K_SIDE = SUM_W'(KERN_SIDE);
	localparam logic signed [SUM_W-1:0] K_MID  = SUM_W'(KERN_MID);

	// [0..2]: column c-2 top/mid/bottom, [3..5]: column c-1
	logic [PIX_W-1:0] win_q [2*WIN_SIZE];

	logic signed [SUM_W-1:0] tl, ml, bl, tc, bc;
	logic signed [SUM_W-1:0] tr, mr, br;
	logic signed [SUM_W-1:0] gx_full, gy_full;

	// shift the window by one column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2*WIN_SIZE; i++) begin
				win_q[i] <= '0;
			end
		end else if (shift_en) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top;
			win_q[4] <= mid;
			win_q[5] <= bot;
		end
	end

	// zero-extended taps
	assign tl = signed'(SUM_W'(win_q[0]));
	assign ml = signed'(SUM_W'(win_q[1]));
	assign bl = signed'(SUM_W'(win_q[2]));
	assign tc = signed'(SUM_W'(win_q[3]));
	assign bc = signed'(SUM_W'(win_q[5]));
	assign tr = signed'(SUM_W'(top));
	assign mr = signed'(SUM_W'(mid));
	assign br = signed'(SUM_W'(bot));

	// kernel sums
	assign gx_full = K_SIDE * (tr - tl + br - bl) + K_MID * (mr - ml);
	assign gy_full = K_SIDE * (bl + br - tl - tr) + K_MID * (bc - tc);

	assign grad_x = gx_full[GRAD_W-1:0];
	assign grad_y = gy_full[GRAD_W-1:0];

endmodule

// ===== src/scharr_3x3_gradient_top.sv =====
// Top level of the streaming Scharr 3x3 gradient filter.
// Depends on sch3_pkg, sch3_ctrl, sch3_ram and sch3_window.

// The block takes one 8-bit pixel per clock in raster order and, for every
// pixel that completes a 3x3 window, gives grad_x and grad_y together with
// row_end and frame_end marks; the output frame is (width-2) by (height-2)
// and images narrower or shorter than 3 give no results. Throughput is one
// pixel per cycle unless a result waits on a full, stalled output register; a
// pixel passes the stage 1 register, beside the registered read of the line
// store RAM, and then the output register. The line store is a single RAM
// with one read and one write port, read for the incoming pixel while the
// previous pixel writes back. A write to image_width or image_height
// restarts the frame and must be done while the block is idle.

module scharr_3x3_gradient_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [sch3_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sch3_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [sch3_pkg::PIX_W-1:0]         pixel,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [sch3_pkg::GRAD_W-1:0] grad_x,
	output logic signed [sch3_pkg::GRAD_W-1:0] grad_y,
	output logic                               row_end,
	output logic                               frame_end
);
	import sch3_pkg::*;

	logic                      accept;
	logic [ADDR_W-1:0]         rd_addr;
	item_tag_t                 tag;

	logic                      valid_s1;
	logic [PIX_W-1:0]          pixel_s1;
	logic [ADDR_W-1:0]         addr_s1;
	item_tag_t                 tag_s1;
	logic                      adv_s1;

	logic [2*PIX_W-1:0]        ls_rd_data;
	logic [PIX_W-1:0]          top, mid;
	logic signed [GRAD_W-1:0]  gx, gy;

	logic                      valid_s2;
	logic signed [GRAD_W-1:0]  grad_x_s2, grad_y_s2;
	logic                      row_end_s2, frame_end_s2;

	// handshake: stage 1 moves on unless it holds a result and the output is full and not ready
	assign adv_s1   = valid_s1 && (!tag_s1.produce || !valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign accept   = in_valid && in_ready;

	// position counters and configuration
	sch3_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (accept),
		.addr      (rd_addr),
		.tag       (tag)
	);

	// line stores: older row in the upper byte, newer row in the lower byte
	sch3_ram #(
		.DATA_W (2*PIX_W),
		.DEPTH  (MAX_WIDTH)
	) u_line_store (
		.clk     (clk),
		.wr_en   (adv_s1),
		.wr_addr (addr_s1),
		.wr_data ({mid, pixel_s1}),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.rd_data (ls_rd_data)
	);

	assign top = ls_rd_data[2*PIX_W-1:PIX_W];
	assign mid = ls_rd_data[PIX_W-1:0];

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1 <= pixel;
			addr_s1  <= rd_addr;
			tag_s1   <= tag;
		end
	end

	// window and gradient arithmetic
	sch3_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift_en (adv_s1),
		.top      (top),
		.mid      (mid),
		.bot      (pixel_s1),
		.grad_x   (gx),
		.grad_y   (gy)
	);

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1 && tag_s1.produce) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (adv_s1 && tag_s1.produce) begin
			grad_x_s2    <= gx;
			grad_y_s2    <= gy;
			row_end_s2   <= tag_s1.row_end;
			frame_end_s2 <= tag_s1.frame_end;
		end
	end

	assign out_valid = valid_s2;
	assign grad_x    = grad_x_s2;
	assign grad_y    = grad_y_s2;
	assign row_end   = row_end_s2;
	assign frame_end = frame_end_s2;

endmodule

// ===== src/sch3_checker.sv =====
// Port-level checks for the Scharr 3x3 gradient top level, bound to it below.
// Depends on sch3_pkg for port widths.

module sch3_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic signed [sch3_pkg::GRAD_W-1:0] grad_x,
	input logic signed [sch3_pkg::GRAD_W-1:0] grad_y,
	input logic                               row_end,
	input logic                               frame_end
);
	import sch3_pkg::*;

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(grad_x) && $stable(grad_y)
			&& $stable(row_end) && $stable(frame_end))
		else $error("stalled result changed or dropped");

	// end of frame is always also end of row
	a_frame_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!frame_end || row_end))
		else $error("frame_end without row_end");

	// an empty output never blocks the input
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while output empty");

	// a new result follows an input transaction through stage 1 and the output register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a matching input transaction");

endmodule

bind scharr_3x3_gradient_top sch3_checker u_sch3_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.grad_x    (grad_x),
	.grad_y    (grad_y),
	.row_end   (row_end),
	.frame_end (frame_end)
);

// ===== verif/scharr_3x3_gradient_checker.sv =====
// Checker for the Scharr 3x3 gradient block: predicts gradients and compares results.
// Depends on sch3_pkg; instantiated beside the block by scharr_3x3_gradient_top_tb.

module scharr_3x3_gradient_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [sch3_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sch3_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic [sch3_pkg::PIX_W-1:0]         pixel,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic signed [sch3_pkg::GRAD_W-1:0] grad_x,
	input  logic signed [sch3_pkg::GRAD_W-1:0] grad_y,
	input  logic                               row_end,
	input  logic                               frame_end,
	output int                                 fail_count,
	output int                                 pending,
	output int                                 pixel_count,
	output int                                 result_count,
	output int                                 frame_count
);

	import sch3_pkg::*;

	// cap on printed mismatches so a broken block cannot flood the log
	localparam int REPORT_LIMIT = 40;

	typedef struct packed {
		logic signed [GRAD_W-1:0] grad_x;
		logic signed [GRAD_W-1:0] grad_y;
		logic                     row_end;
		logic                     frame_end;
	} gradient_t;

	gradient_t expected_grads[$];

	// predicted block state
	logic [PIX_W-1:0]    older_line [MAX_WIDTH];
	logic [PIX_W-1:0]    newer_line [MAX_WIDTH];
	logic [PIX_W-1:0]    win_cols [6];
	logic [WIDTH_W-1:0]  width_reg;
	logic [HEIGHT_W-1:0] height_reg;
	int unsigned         col_pos;
	int unsigned         row_pos;

	// one pixel transaction: expected gradients and state update
	task automatic predict_gradients(input logic [PIX_W-1:0] bot_pix);
		int unsigned w;
		int unsigned h;
		int unsigned c;
		int unsigned r;
		logic [PIX_W-1:0] top_pix;
		logic [PIX_W-1:0] mid_pix;
		int t, m, b, tl, ml, bl, tc, bc, gx, gy;
		gradient_t res;
		w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
		h = (height_reg == 0) ? 1 : height_reg;
		c = col_pos;
		r = row_pos;
		if (c >= w)
			c = w - 1;
		top_pix = older_line[c];
		mid_pix = newer_line[c];
		if (w >= 3 && h >= 3 && r >= 2 && c >= 2) begin
			t  = top_pix;
			m  = mid_pix;
			b  = bot_pix;
			tl = win_cols[0];
			ml = win_cols[1];
			bl = win_cols[2];
			tc = win_cols[3];
			bc = win_cols[5];
			gx = KERN_SIDE * (t - tl + b - bl) + KERN_MID * (m - ml);
			gy = KERN_SIDE * (bl + b - tl - t) + KERN_MID * (bc - tc);
			res.grad_x    = gx[GRAD_W-1:0];
			res.grad_y    = gy[GRAD_W-1:0];
			res.row_end   = (c == w - 1);
			res.frame_end = (c == w - 1) && (r == h - 1);
			expected_grads.push_back(res);
		end
		// window slides one column, line stores shift down one row
		win_cols[0] = win_cols[3];
		win_cols[1] = win_cols[4];
		win_cols[2] = win_cols[5];
		win_cols[3] = top_pix;
		win_cols[4] = mid_pix;
		win_cols[5] = bot_pix;
		older_line[c] = mid_pix;
		newer_line[c] = bot_pix;
		// raster position, wrapping at row and frame end
		if (c + 1 >= w) begin
			col_pos = 0;
			row_pos = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
			row_pos = r;
		end
	endtask

	// one result transaction against the oldest prediction
	task automatic check_result();
		gradient_t want;
		if (expected_grads.size() == 0) begin
			fail_count++;
			if (fail_count <= REPORT_LIMIT)
				$error("unexpected result: grad_x %0d grad_y %0d", grad_x, grad_y);
		end else begin
			want = expected_grads.pop_front();
			if (grad_x !== want.grad_x) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$error("grad_x: expected %0d, actual %0d", $signed(want.grad_x), grad_x);
			end
			if (grad_y !== want.grad_y) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$error("grad_y: expected %0d, actual %0d", $signed(want.grad_y), grad_y);
			end
			if (row_end !== want.row_end) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$error("row_end: expected %0b, actual %0b", want.row_end, row_end);
			end
			if (frame_end !== want.frame_end) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$error("frame_end: expected %0b, actual %0b", want.frame_end, frame_end);
			end
		end
		result_count++;
		if (frame_end === 1'b1)
			frame_count++;
	endtask

	// monitor: results first, then register writes, then pixels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_grads.delete();
			for (int i = 0; i < MAX_WIDTH; i++) begin
				older_line[i] = '0;
				newer_line[i] = '0;
			end
			for (int i = 0; i < 6; i++)
				win_cols[i] = '0;
			width_reg  = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			col_pos    = 0;
			row_pos    = 0;
			pending    = 0;
		end else begin
			if (out_valid && out_ready)
				check_result();
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_IMAGE_WIDTH:  width_reg  = cfg_data[WIDTH_W-1:0];
					REG_IMAGE_HEIGHT: height_reg = cfg_data[HEIGHT_W-1:0];
					default: ;
				endcase
				col_pos = 0;
				row_pos = 0;
			end
			if (in_valid && in_ready) begin
				pixel_count++;
				predict_gradients(pixel);
			end
			pending = expected_grads.size();
		end
	end

endmodule

// ===== verif/scharr_3x3_gradient_top_tb.sv =====
// Testbench top for the Scharr 3x3 gradient block: stimulus, flow control and verdict.
// Depends on sch3_pkg, scharr_3x3_gradient_top and scharr_3x3_gradient_checker.

module scharr_3x3_gradient_top_tb;

	import sch3_pkg::*;

	// cycles without any transaction before the run is declared hung
	localparam int STALL_LIMIT = 4000;
	// random pixels per flow-control stage that can produce results
	localparam int STAGE_PIXELS = 350;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = REG_IMAGE_WIDTH;
	logic [CFG_DATA_W-1:0]    cfg_data  = '0;
	logic                     in_valid  = 1'b0;
	logic                     in_ready;
	logic [PIX_W-1:0]         pixel     = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [GRAD_W-1:0] grad_x;
	logic signed [GRAD_W-1:0] grad_y;
	logic                     row_end;
	logic                     frame_end;

	int fail_count;
	int pending;
	int pixel_count;
	int result_count;
	int frame_count;
	int send_idle_pct = 27;
	int recv_idle_pct = 73;
	int stall_cycles  = 0;
	int geometry_count = 0;

	always #5 clk = ~clk;

	scharr_3x3_gradient_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel     (pixel),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.grad_x    (grad_x),
		.grad_y    (grad_y),
		.row_end   (row_end),
		.frame_end (frame_end)
	);

	scharr_3x3_gradient_checker grad_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel        (pixel),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.grad_x       (grad_x),
		.grad_y       (grad_y),
		.row_end      (row_end),
		.frame_end    (frame_end),
		.fail_count   (fail_count),
		.pending      (pending),
		.pixel_count  (pixel_count),
		.result_count (result_count),
		.frame_count  (frame_count)
	);

	// result side back-pressure
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// hang detection
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("** scharr_3x3_gradient_top: FAILED **");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// one pixel transaction, with random gaps ahead of it
	task automatic push_pixel(input logic [PIX_W-1:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			pixel    = PIX_W'($urandom);
			@(negedge clk);
		end
		in_valid = 1'b1;
		pixel    = value;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// wait for all results plus the pipeline depth
	task automatic drain_block();
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	task automatic set_geometry(input logic [CFG_DATA_W-1:0] width_data,
			input logic [CFG_DATA_W-1:0] height_data);
		drain_block();
		write_reg(REG_IMAGE_WIDTH, width_data);
		write_reg(REG_IMAGE_HEIGHT, height_data);
		geometry_count++;
	endtask

	// either full-range values or only the two extremes
	function automatic logic [PIX_W-1:0] pick_pixel(input logic harsh);
		if (harsh)
			return $urandom_range(1) ? {PIX_W{1'b1}} : '0;
		return PIX_W'($urandom_range(255));
	endfunction

	// one random geometry followed by whole, repeated or cut-off frames
	task automatic random_phase(inout int counted);
		logic [WIDTH_W-1:0]  w_val;
		logic [HEIGHT_W-1:0] h_val;
		int w_eff;
		int h_eff;
		int count;
		logic harsh;
		case ($urandom_range(19))
			0: w_val = '0;
			1: w_val = WIDTH_W'(1);
			2: w_val = WIDTH_W'(2);
			3: w_val = WIDTH_W'(MAX_WIDTH);
			4: w_val = WIDTH_W'($urandom_range(MAX_WIDTH + 1, 8191));
			default: w_val = WIDTH_W'($urandom_range(3, 12));
		endcase
		case ($urandom_range(11))
			0: h_val = '0;
			1: h_val = HEIGHT_W'(1);
			2: h_val = HEIGHT_W'(2);
			3: h_val = {HEIGHT_W{1'b1}};
			4: h_val = HEIGHT_W'($urandom_range(7, 65534));
			default: h_val = HEIGHT_W'($urandom_range(3, 6));
		endcase
		w_eff = (w_val == 0) ? 1 : ((w_val > MAX_WIDTH) ? MAX_WIDTH : w_val);
		h_eff = (h_val == 0) ? 1 : h_val;
		// upper data bits are outside the width register and must be dropped
		set_geometry({3'($urandom), w_val}, h_val);
		if (w_eff >= 1024)
			count = $urandom_range(1, 40);
		else if (h_eff > 6)
			count = w_eff * $urandom_range(3, 9) + $urandom_range(0, w_eff - 1);
		else if ($urandom_range(3) == 0)
			count = w_eff * h_eff * $urandom_range(1, 2) + $urandom_range(0, w_eff * h_eff - 1);
		else
			count = w_eff * h_eff * $urandom_range(1, 2);
		harsh = ($urandom_range(3) == 0);
		for (int i = 0; i < count; i++)
			push_pixel(pick_pixel(harsh));
		if (w_eff >= 3 && h_eff >= 3)
			counted += count;
	endtask

	initial begin
		int counted;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset geometry: a few pixels of the first row, none may give a result
		for (int i = 0; i < 16; i++)
			push_pixel(pick_pixel(1'b0));

		// step across columns: full positive then full negative grad_x
		set_geometry(CFG_DATA_W'(4), CFG_DATA_W'(3));
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 4; c++)
				push_pixel((c == 1 || c == 2) ? {PIX_W{1'b1}} : '0);

		// step across rows: full positive then full negative grad_y
		set_geometry(CFG_DATA_W'(3), CFG_DATA_W'(4));
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 3; c++)
				push_pixel((r == 1 || r == 2) ? {PIX_W{1'b1}} : '0);

		// random geometries under three flow-control patterns
		for (int stage = 0; stage < 3; stage++) begin
			send_idle_pct = (stage == 0) ? 27 : ((stage == 1) ? 73 : 0);
			recv_idle_pct = (stage == 0) ? 73 : ((stage == 1) ? 27 : 0);
			counted = 0;
			while (counted < STAGE_PIXELS)
				random_phase(counted);
		end

		drain_block();
		repeat (4) @(negedge clk);
		$display("covered %0d pixels over %0d geometries, %0d gradient results, %0d frames ended",
			pixel_count, geometry_count + 1, result_count, frame_count);
		if (fail_count == 0) begin
			$display("** scharr_3x3_gradient_top: PASSED **");
		end else begin
			$display("** scharr_3x3_gradient_top: FAILED **");
		end
		$finish;
	end

endmodule
